// ===== design/armu_pkg.sv =====
// Shared constants, codes and word types for the atomic read-modify-write memory unit.
package armu_pkg;

  localparam int unsigned StoreWords = 512;
  localparam int unsigned StoreBytes = StoreWords * 8;
  localparam int unsigned WordIdxW   = (StoreWords > 1) ? $clog2(StoreWords) : 1;
  localparam int unsigned AddrW      = 20;
  localparam int unsigned EndW       = AddrW + 1;

  typedef enum logic [3:0] {
    KIND_ADD   = 4'd0,
    KIND_AND   = 4'd1,
    KIND_CAS   = 4'd2,
    KIND_XCHG  = 4'd3,
    KIND_LOAD  = 4'd4,
    KIND_OR    = 4'd5,
    KIND_STORE = 4'd6,
    KIND_SUB   = 4'd7,
    KIND_XOR   = 4'd8
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_RANGE  = 2'd1,
    STAT_BOUNDS = 2'd2
  } status_t;

  // Classified request as it waits between front and back.
  typedef struct packed {
    kind_t                 kind;
    logic                  is_signed;
    logic [1:0]            lg;
    logic [WordIdxW-1:0]   widx;
    logic [2:0]            bsel;
    status_t               status;
    logic [63:0]           operand;
    logic [63:0]           expected;
  } cmd_t;

  typedef struct packed {
    logic [63:0] value;
    status_t     status;
  } res_t;

endpackage

// ===== design/armu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module armu_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 512,
  localparam int unsigned AW   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem_r [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/armu_front.sv =====
// Front end: accept requests, check range and bounds, queue classified words for the back end.
module armu_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic [3:0]           in_kind,
  input  logic [2:0]           in_elem_type,
  input  logic [11:0]          in_base_offset,
  input  logic [12:0]          in_elem_count,
  input  logic [15:0]          in_index,
  input  logic [63:0]          in_operand,
  input  logic [63:0]          in_expected,
  input  logic                 hold,
  output logic                 cmd_valid,
  output armu_pkg::cmd_t       cmd,
  input  logic                 cmd_pop
);
  import armu_pkg::*;

  cmd_t                q_r [2];
  logic                wp_r, wp_nxt;
  logic                rp_r, rp_nxt;
  logic [1:0]          cnt_r, cnt_nxt;
  logic                accept;

  logic [1:0]          lg;
  logic [11:0]         base_al;
  logic [AddrW-1:0]    addr;
  logic [EndW-1:0]     addr_end;
  logic                out_range;
  logic                out_bounds;
  cmd_t                cmd_new;

  // Round the base down to alignment, then locate the element.
  always_comb begin
    lg         = in_elem_type[2:1];
    base_al    = in_base_offset & ~((12'd1 << lg) - 12'd1);
    addr       = AddrW'(base_al) + (AddrW'(in_index) << lg);
    addr_end   = EndW'(addr) + (EndW'(1) << lg);
    out_range  = in_index >= {3'b000, in_elem_count};
    out_bounds = addr_end > EndW'(StoreBytes);

    cmd_new.kind      = kind_t'(in_kind);
    cmd_new.is_signed = ~in_elem_type[0];
    cmd_new.lg        = lg;
    cmd_new.widx      = addr[3 +: WordIdxW];
    cmd_new.bsel      = addr[2:0];
    cmd_new.operand   = in_operand;
    cmd_new.expected  = in_expected;
    if (out_range) begin
      cmd_new.status = STAT_RANGE;
    end else if (out_bounds) begin
      cmd_new.status = STAT_BOUNDS;
    end else begin
      cmd_new.status = STAT_OK;
    end
  end

  assign full      = hold | (cnt_r == 2'd2);
  assign accept    = push & ~full;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ accept;
    rp_nxt  = rp_r ^ cmd_pop;
    cnt_nxt = cnt_r + 2'(accept) - 2'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wp_r] <= cmd_new;
    end
  end

`ifndef NO_ASSERTIONS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cnt_r != 2'd0) else $error("front queue popped while empty");
`endif

endmodule

// ===== design/armu_back.sv =====
// Back end: clear the store, then read, modify and write back one element per request.
module armu_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  input  armu_pkg::cmd_t   cmd,
  output logic             cmd_pop,
  output logic             clearing,
  output logic             empty,
  input  logic             pop,
  output logic [63:0]      out_value,
  output logic [1:0]       out_status
);
  import armu_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  logic [WordIdxW-1:0]   clr_idx_r, clr_idx_nxt;
  cmd_t                  cmd_r;
  logic                  issue;

  logic                  ram_we;
  logic [WordIdxW-1:0]   ram_waddr;
  logic [63:0]           ram_wdata;
  logic [63:0]           ram_rdata;

  logic [5:0]            sh;
  logic [63:0]           mask;
  logic [63:0]           oldbits;
  logic [63:0]           opnd;
  logic [63:0]           newbits;
  logic                  wr;
  logic                  sign_bit;
  logic [63:0]           ext;
  logic [63:0]           merged;
  res_t                  res_new;

  res_t                  res_r [2];
  logic                  owp_r, orp_r;
  logic [1:0]            ocnt_r, ocnt_nxt;
  logic                  res_push;
  logic                  res_pop;

  armu_ram #(.Width(64), .Depth(StoreWords)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cmd.widx),
    .rdata (ram_rdata)
  );

  // Start a request only when the result queue has room for it.
  assign issue    = (state_r == S_IDLE) && cmd_valid && (ocnt_r != 2'd2);
  assign cmd_pop  = issue;
  assign clearing = (state_r == S_CLEAR);
  assign res_push = (state_r == S_EXEC);

  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_idx_nxt = clr_idx_r + WordIdxW'(1);
        if (clr_idx_r == WordIdxW'(StoreWords - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (issue) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      cmd_r <= cmd;
    end
  end

  // Element extract, operate, merge.
  always_comb begin
    sh = {cmd_r.bsel, 3'b000};
    unique case (cmd_r.lg)
      2'd0:    mask = 64'h0000_0000_0000_00ff;
      2'd1:    mask = 64'h0000_0000_0000_ffff;
      2'd2:    mask = 64'h0000_0000_ffff_ffff;
      default: mask = 64'hffff_ffff_ffff_ffff;
    endcase
    oldbits = (ram_rdata >> sh) & mask;
    opnd    = cmd_r.operand & mask;
    newbits = oldbits;
    wr      = 1'b1;
    unique case (cmd_r.kind) inside
      KIND_ADD:              newbits = oldbits + opnd;
      KIND_SUB:              newbits = oldbits - opnd;
      KIND_AND:              newbits = oldbits & opnd;
      KIND_OR:               newbits = oldbits | opnd;
      KIND_XOR:              newbits = oldbits ^ opnd;
      KIND_XCHG, KIND_STORE: newbits = opnd;
      KIND_CAS: begin
        if (oldbits == (cmd_r.expected & mask)) begin
          newbits = opnd;
        end else begin
          wr = 1'b0;
        end
      end
      default:               wr = 1'b0;
    endcase
    merged = (ram_rdata & ~(mask << sh)) | ((newbits & mask) << sh);

    unique case (cmd_r.lg)
      2'd0:    sign_bit = oldbits[7];
      2'd1:    sign_bit = oldbits[15];
      2'd2:    sign_bit = oldbits[31];
      default: sign_bit = oldbits[63];
    endcase
    ext = oldbits | ((cmd_r.is_signed && sign_bit) ? ~mask : 64'd0);

    res_new.status = cmd_r.status;
    if (cmd_r.status != STAT_OK) begin
      res_new.value = 64'd0;
    end else if (cmd_r.kind == KIND_STORE) begin
      res_new.value = cmd_r.operand;
    end else begin
      res_new.value = ext;
    end
  end

  // Clear sweep owns the write port until it finishes.
  always_comb begin
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx_r;
      ram_wdata = 64'd0;
    end else begin
      ram_we    = (state_r == S_EXEC) && wr && (cmd_r.status == STAT_OK);
      ram_waddr = cmd_r.widx;
      ram_wdata = merged;
    end
  end

  // Result queue.
  assign res_pop    = pop && (ocnt_r != 2'd0);
  assign empty      = (ocnt_r == 2'd0);
  assign out_value  = res_r[orp_r].value;
  assign out_status = res_r[orp_r].status;

  always_comb begin
    ocnt_nxt = ocnt_r + 2'(res_push) - 2'(res_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      owp_r  <= owp_r ^ res_push;
      orp_r  <= orp_r ^ res_pop;
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_r[owp_r] <= res_new;
    end
  end

`ifndef NO_ASSERTIONS
  a_room_at_push: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |-> ocnt_r != 2'd2) else $error("result pushed into full queue");
  a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |=> state_r == S_IDLE) else $error("execute stage held");
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !ram_we) else $error("store written while idle");
`endif

endmodule

// ===== design/atomic_rmw_memory_unit.sv =====
// Top level of the atomic read-modify-write memory unit.
//
// Atomic read-modify-write unit over a private store of 512 64-bit words. Each
// request word carries an operation (add, sub, and, or, xor, exchange,
// compare-and-swap, load, store), an element type (8/16/32/64 bits, signed or
// unsigned), an array view (byte base, element count) and an index. The front
// end checks the index against the count (status 1) and the element against
// the end of the store (status 2) and queues the classified request; failing
// requests return value 0 and leave the store alone. The back end reads the
// word, then computes, writes back and queues the result in the next cycle;
// it takes no new request until it has finished the one before. The value
// returned is the old element sign- or zero-extended, or the full operand for
// store; unknown operation codes behave as load. After reset the unit sweeps
// the store to zero, one word a cycle; full stays high during that sweep.
// Both sides behave as queues: push/full on the request side, empty/pop on
// the result side, and a waiting result never blocks new requests until both
// internal queues are full.
module atomic_rmw_memory_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  output logic         full,
  input  logic [3:0]   in_kind,
  input  logic [2:0]   in_elem_type,
  input  logic [11:0]  in_base_offset,
  input  logic [12:0]  in_elem_count,
  input  logic [15:0]  in_index,
  input  logic [63:0]  in_operand,
  input  logic [63:0]  in_expected,
  output logic         empty,
  input  logic         pop,
  output logic [63:0]  out_value,
  output logic [1:0]   out_status
);
  import armu_pkg::*;

  logic  cmd_valid;
  cmd_t  cmd;
  logic  cmd_pop;
  logic  clearing;

  // Classify and queue requests.
  armu_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_kind        (in_kind),
    .in_elem_type   (in_elem_type),
    .in_base_offset (in_base_offset),
    .in_elem_count  (in_elem_count),
    .in_index       (in_index),
    .in_operand     (in_operand),
    .in_expected    (in_expected),
    .hold           (clearing),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop)
  );

  // Execute against the store and queue results.
  armu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .clearing   (clearing),
    .empty      (empty),
    .pop        (pop),
    .out_value  (out_value),
    .out_status (out_status)
  );

endmodule
